// ----- src/lcpe_pkg.sv -----
// shared types and constants of the locomotive command packet encoder
package lcpe_pkg;

  localparam int unsigned DefAddressCount = 256;
  localparam int unsigned PacketHalfBits  = 18;
  localparam int unsigned MaxAddress      = 80;
  localparam int unsigned MaxStepHalf     = 28;
  localparam int unsigned MaxStep         = 15;

  // protocol_mode codes, the unused code behaves as the 14-step mode
  localparam logic [1:0] ModeStep14 = 2'd0;
  localparam logic [1:0] ModeHalf28 = 2'd1;
  localparam logic [1:0] ModeKeep1  = 2'd2;

  // speed trit masks, second half-bits of trits 5..8
  localparam logic [3:0] MaskRevFast = 4'h5;
  localparam logic [3:0] MaskRevSlow = 4'hD;
  localparam logic [3:0] MaskFwdSlow = 4'hA;
  localparam logic [3:0] MaskFwdFast = 4'h2;

  localparam logic StatusOk     = 1'b0;
  localparam logic StatusReject = 1'b1;
  localparam logic KindSpeed    = 1'b0;
  localparam logic KindFunction = 1'b1;

  typedef struct packed {
    logic [7:0] loco_address;
    logic       direction;
    logic [4:0] speed_step;
    logic       light_on;
    logic [3:0] fn_bits;     // bit i is function i+1
  } cmd_t;

  typedef struct packed {
    logic                      status;
    logic [7:0]                target_address;
    logic [PacketHalfBits-1:0] packet_bits;
    logic                      packet_kind;
    logic [1:0]                function_index;
  } res_t;

  // access to the function store
  typedef struct packed {
    logic       rd_en;
    logic [7:0] rd_addr;
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [3:0] wr_data;
  } st_req_t;

endpackage

// ----- src/lcpe_store.sv -----
// per-address function bit store, registered read, valid bits emulate the cleared reset
module lcpe_store #(
  parameter int unsigned ADDRESS_COUNT = lcpe_pkg::DefAddressCount
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lcpe_pkg::st_req_t req_i,
  output logic [3:0]        rd_bits_o
);
  import lcpe_pkg::*;

  localparam int unsigned AW = $clog2(ADDRESS_COUNT);

  logic [3:0]               mem [ADDRESS_COUNT];
  logic [ADDRESS_COUNT-1:0] vld_q;
  logic [3:0]               rd_data_q;
  logic                     rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr[AW-1:0]] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr[AW-1:0]] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr[AW-1:0]];
      end
    end
  end

  // an entry never written reads as all functions off
  assign rd_bits_o = rd_vld_q ? rd_data_q : 4'h0;

endmodule

// ----- src/lcpe_format.sv -----
// builds the trit packet from one command, the mode and the stored function bits
module lcpe_format (
  input  lcpe_pkg::cmd_t  cmd_i,
  input  logic [1:0]      mode_i,
  input  logic [3:0]      stored_i,
  output lcpe_pkg::res_t  res_o
);
  import lcpe_pkg::*;

  // base-3 digits of the address, least significant first
  function automatic logic [7:0] addr_halves(input logic [7:0] addr);
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [7:0]  q [5];
    logic [7:0]  r;
    logic [7:0]  h;
    // quotients by 3, 9 and 27 side by side, exact for 8-bit values
    p1 = addr * 16'd171;
    p2 = addr * 16'd57;
    p3 = addr * 16'd19;
    q[0] = addr;
    q[1] = {1'b0, p1[15:9]};
    q[2] = {3'b0, p2[13:9]};
    q[3] = {4'b0, p3[12:9]};
    q[4] = (q[3] >= 8'd9) ? 8'd3 :
           (q[3] >= 8'd6) ? 8'd2 :
           (q[3] >= 8'd3) ? 8'd1 : 8'd0;
    h = '0;
    for (int i = 0; i < 4; i++) begin
      r = q[i] - (q[i+1] * 8'd3);
      h[2*i]   = (r[1:0] != 2'd0);
      h[2*i+1] = (r[1:0] == 2'd1);
    end
    return h;
  endfunction

  logic                      half_mode;
  logic                      keep_one;
  logic                      reject;
  logic [5:0]                n_inc;
  logic [4:0]                m;
  logic [3:0]                v;
  logic [3:0]                mask;
  logic [3:0]                diff;
  logic [1:0]                j;
  logic                      fbit;
  logic [2:0]                sel;
  logic [3:0]                low_step;
  logic [3:0]                high_step;
  logic [PacketHalfBits-1:0] pkt;

  always_comb begin
    half_mode = (mode_i == ModeHalf28);
    keep_one  = (mode_i == ModeKeep1);
    reject    = (cmd_i.loco_address > 8'(MaxAddress)) ||
                (half_mode ? (cmd_i.speed_step > 5'(MaxStepHalf))
                           : (cmd_i.speed_step > 5'(MaxStep)));

    n_inc = {1'b0, cmd_i.speed_step} + 6'd1;
    m     = half_mode ? (5'(n_inc[5:1]) + 5'd1) : cmd_i.speed_step;
    v     = (m == 5'd1 && !keep_one) ? 4'd0 : m[3:0];
    if (cmd_i.direction) begin
      mask = (m > 5'd7) ? MaskFwdFast : MaskFwdSlow;
    end else begin
      mask = (m > 5'd7) ? MaskRevFast : MaskRevSlow;
    end

    pkt = '0;
    pkt[7:0] = addr_halves(cmd_i.loco_address);
    pkt[8]   = cmd_i.light_on;
    // half step marks the light trit as open or unused
    pkt[9]   = (half_mode && !cmd_i.speed_step[0]) ? !cmd_i.light_on : cmd_i.light_on;
    for (int i = 0; i < 4; i++) begin
      pkt[10+2*i] = v[i];
      pkt[11+2*i] = mask[i];
    end

    diff = stored_i ^ cmd_i.fn_bits;
    priority if (diff[0]) j = 2'd0;
    else if (diff[1])     j = 2'd1;
    else if (diff[2])     j = 2'd2;
    else                  j = 2'd3;
    fbit = cmd_i.fn_bits[j];

    // select pattern on half-bits 11, 13, 15 and the steps that clash with it
    unique case (j)
      2'd0: begin sel = 3'b011; low_step = 4'd3; high_step = 4'd11; end
      2'd1: begin sel = 3'b100; low_step = 4'd4; high_step = 4'd12; end
      2'd2: begin sel = 3'b110; low_step = 4'd6; high_step = 4'd14; end
      default: begin sel = 3'b111; low_step = 4'd7; high_step = 4'd15; end
    endcase
    if (m == {1'b0, low_step} && !fbit) begin
      sel = 3'b101;
    end
    if (m == {1'b0, high_step} && fbit) begin
      sel = 3'b010;
    end

    res_o.target_address = cmd_i.loco_address;
    if (reject) begin
      res_o.status         = StatusReject;
      res_o.packet_bits    = '0;
      res_o.packet_kind    = KindSpeed;
      res_o.function_index = 2'd0;
    end else if (diff == 4'h0) begin
      res_o.status         = StatusOk;
      res_o.packet_bits    = pkt;
      res_o.packet_kind    = KindSpeed;
      res_o.function_index = 2'd0;
    end else begin
      res_o.status         = StatusOk;
      res_o.packet_bits    = pkt;
      res_o.packet_bits[11] = sel[0];
      res_o.packet_bits[13] = sel[1];
      res_o.packet_bits[15] = sel[2];
      res_o.packet_bits[17] = fbit;
      res_o.packet_kind    = KindFunction;
      res_o.function_index = j;
    end
  end

endmodule

// ----- src/loco_command_packet_encoder.sv -----
// locomotive command packet encoder: takes a command word, gives one packet word
// the accepted word and its store read are registered, then the result is registered at the output when it is free
// a new word is taken only once the last has left the busy state, set by the read-modify-write of the function store
// the input side stays open while a finished word waits at the output
// reset clears mode, handshake state and the store's valid bits; no clearing pass
module loco_command_packet_encoder #(
  parameter int unsigned ADDRESS_COUNT = lcpe_pkg::DefAddressCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,      // protocol_mode
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // loco_address[7:0], direction[8], speed_step[13:9], light_on[14],
  // function_one[15], function_two[16], function_three[17], function_four[18]
  input  logic [23:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[0], target_address[8:1], packet_bits[26:9]
  output logic [31:0] m_axis_tdata_o,
  // packet_kind[0], function_index[2:1]
  output logic [2:0]  m_axis_tuser_o
);
  import lcpe_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StBusy = 1'b1;

  logic    state_q, state_d;
  logic [1:0] mode_q;
  cmd_t    cmd_q;
  cmd_t    cmd_in;
  res_t    res;
  res_t    out_q;
  logic    out_vld_q;
  logic    in_acc;
  logic    done;
  logic [3:0] stored;
  st_req_t st_req;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeStep14;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  assign cmd_in.loco_address = s_axis_tdata_i[7:0];
  assign cmd_in.direction    = s_axis_tdata_i[8];
  assign cmd_in.speed_step   = s_axis_tdata_i[13:9];
  assign cmd_in.light_on     = s_axis_tdata_i[14];
  assign cmd_in.fn_bits      = s_axis_tdata_i[18:15];

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  // the result leaves the busy state only when the output slot can take it
  assign done            = (state_q == StBusy) && (!out_vld_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_acc) state_d = StBusy;
      default: if (done)   state_d = StIdle;
    endcase
  end

  // read on accept, write back when a word that is not rejected is delivered to the output slot
  assign st_req.rd_en   = in_acc;
  assign st_req.rd_addr = cmd_in.loco_address;
  assign st_req.wr_en   = done && (res.status == StatusOk);
  assign st_req.wr_addr = cmd_q.loco_address;
  assign st_req.wr_data = cmd_q.fn_bits;

  lcpe_store #(
    .ADDRESS_COUNT(ADDRESS_COUNT)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (st_req),
    .rd_bits_o(stored)
  );

  lcpe_format u_format (
    .cmd_i   (cmd_q),
    .mode_i  (mode_q),
    .stored_i(stored),
    .res_o   (res)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= cmd_in;
    end
    if (done) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'd0, out_q.packet_bits, out_q.target_address, out_q.status};
  assign m_axis_tuser_o  = {out_q.function_index, out_q.packet_kind};

endmodule
